### sv/ppou_pkg.sv
// Shared types, register indexes and helper functions for the pixel point operation unit.
`default_nettype none
package ppou_pkg;

    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned CONST_W     = 9;
    localparam int unsigned OP_W        = 3;
    localparam int unsigned IDX_W       = 2;
    localparam int unsigned CFG_DATA_W  = 9;
    localparam int unsigned IN_DATA_W   = 56;
    localparam int unsigned OUT_DATA_W  = 32;
    localparam int unsigned SUM_W       = 11;
    localparam int unsigned LUMA_ACC_W  = 24;

    // Q16 BT.601 luma weights
    localparam logic [15:0] LUMA_WR = 16'd19589;
    localparam logic [15:0] LUMA_WG = 16'd38470;
    localparam logic [15:0] LUMA_WB = 16'd7471;

    localparam logic [CHAN_W-1:0]  CHAN_MAX        = 8'hFF;
    localparam logic [CHAN_W-1:0]  THRESHOLD_RESET = 8'd100;

    localparam logic [IDX_W-1:0] REG_OPERATION = 2'd0;
    localparam logic [IDX_W-1:0] REG_CONSTANT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_CONST  = 3'd0,
        OP_SUB_CONST  = 3'd1,
        OP_ADD_PIXELS = 3'd2,
        OP_SUB_PIXELS = 3'd3,
        OP_GRAY       = 3'd4,
        OP_BINARIZE   = 3'd5
    } op_t;

    typedef struct packed {
        logic        [OP_W-1:0]    operation;
        logic signed [CONST_W-1:0] constant_value;
        logic        [CHAN_W-1:0]  threshold;
    } cfg_t;

    // first field sits in the highest bits
    typedef struct packed {
        logic [CHAN_W-1:0] b_blue;
        logic [CHAN_W-1:0] b_green;
        logic [CHAN_W-1:0] b_red;
        logic [CHAN_W-1:0] a_alpha;
        logic [CHAN_W-1:0] a_blue;
        logic [CHAN_W-1:0] a_green;
        logic [CHAN_W-1:0] a_red;
    } pix_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_alpha;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_red;
    } pix_out_t;

    function automatic logic [CHAN_W-1:0] clamp_byte(input logic signed [SUM_W-1:0] v);
        logic [CHAN_W-1:0] r;
        if (v[SUM_W-1])
            r = '0;
        else if (v[SUM_W-2:CHAN_W] != '0)
            r = CHAN_MAX;
        else
            r = v[CHAN_W-1:0];
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] ext_chan(input logic [CHAN_W-1:0] c);
        return $signed({{(SUM_W-CHAN_W){1'b0}}, c});
    endfunction

endpackage
`default_nettype wire

### sv/ppou_cfg.sv
// Configuration register file: operation, signed constant and binarize threshold.
`default_nettype none
module ppou_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [ppou_pkg::IDX_W-1:0]      cfg_index,
    input  wire logic [ppou_pkg::CFG_DATA_W-1:0] cfg_data,
    output ppou_pkg::cfg_t                  cfg
);
    import ppou_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (cfg_index)
                REG_OPERATION: cfg_next.operation      = cfg_data[OP_W-1:0];
                REG_CONSTANT:  cfg_next.constant_value = $signed(cfg_data[CONST_W-1:0]);
                REG_THRESHOLD: cfg_next.threshold      = cfg_data[CHAN_W-1:0];
                default:       cfg_next = cfg_reg;  // writes past the list are dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.operation      <= OP_ADD_CONST;
            cfg_reg.constant_value <= '0;
            cfg_reg.threshold      <= THRESHOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

### sv/ppou_alu.sv
// Per-pixel datapath: saturating add/sub, BT.601 luma and threshold.
`default_nettype none
module ppou_alu (
    input  wire ppou_pkg::cfg_t    cfg,
    input  wire ppou_pkg::pix_in_t pix,
    output ppou_pkg::pix_out_t     res
);
    import ppou_pkg::*;

    logic signed [SUM_W-1:0]  cst;
    logic signed [SUM_W-1:0]  ar, ag, ab, br, bg, bb;
    logic [LUMA_ACC_W-1:0]    prod_r, prod_g, prod_b;
    logic [LUMA_ACC_W-1:0]    luma_acc;
    logic [CHAN_W-1:0]        luma;
    logic [CHAN_W-1:0]        bin;

    assign cst = {{(SUM_W-CONST_W){cfg.constant_value[CONST_W-1]}}, cfg.constant_value};
    assign ar  = ext_chan(pix.a_red);
    assign ag  = ext_chan(pix.a_green);
    assign ab  = ext_chan(pix.a_blue);
    assign br  = ext_chan(pix.b_red);
    assign bg  = ext_chan(pix.b_green);
    assign bb  = ext_chan(pix.b_blue);

    // constant weights, so these reduce to shift-add networks
    assign prod_r   = LUMA_WR * pix.a_red;
    assign prod_g   = LUMA_WG * pix.a_green;
    assign prod_b   = LUMA_WB * pix.a_blue;
    assign luma_acc = prod_r + prod_g + prod_b;
    assign luma     = luma_acc[LUMA_ACC_W-1 -: CHAN_W];
    assign bin      = (luma >= cfg.threshold) ? CHAN_MAX : '0;

    always_comb
    begin
        res.out_red   = pix.a_red;
        res.out_green = pix.a_green;
        res.out_blue  = pix.a_blue;
        res.out_alpha = pix.a_alpha;
        case (cfg.operation)
            OP_ADD_CONST:
            begin
                res.out_red   = clamp_byte(ar + cst);
                res.out_green = clamp_byte(ag + cst);
                res.out_blue  = clamp_byte(ab + cst);
            end
            OP_SUB_CONST:
            begin
                res.out_red   = clamp_byte(ar - cst);
                res.out_green = clamp_byte(ag - cst);
                res.out_blue  = clamp_byte(ab - cst);
            end
            OP_ADD_PIXELS:
            begin
                res.out_red   = clamp_byte(ar + br);
                res.out_green = clamp_byte(ag + bg);
                res.out_blue  = clamp_byte(ab + bb);
                res.out_alpha = CHAN_MAX;
            end
            OP_SUB_PIXELS:
            begin
                res.out_red   = clamp_byte(ar - br);
                res.out_green = clamp_byte(ag - bg);
                res.out_blue  = clamp_byte(ab - bb);
                res.out_alpha = CHAN_MAX;
            end
            OP_GRAY:     res.out_red = luma;
            OP_BINARIZE: res.out_red = bin;
            default:     res.out_red = pix.a_red;  // unused codes pass A through
        endcase
    end

endmodule
`default_nettype wire

### sv/pixel_point_operation_unit_core.sv
// Path: an input transaction passes the input reg, then the result reg, which drives result valid.
// Throughput: one pixel per cycle while the output is not stalled; the datapath between the two registers is one pass.
// Backpressure stalls both stages together; an input is taken while a result waits
// as long as the input stage is free to move.
// Reset: valid flags cleared, operation 0, constant 0, threshold 100.
`default_nettype none
module pixel_point_operation_unit_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // a_red, a_green, a_blue, a_alpha, b_red, b_green, b_blue (8 bits each)
    input  wire logic [ppou_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_red, out_green, out_blue, out_alpha (8 bits each)
    output logic [ppou_pkg::OUT_DATA_W-1:0]       m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ppou_pkg::IDX_W-1:0]       cfg_index,
    input  wire logic [ppou_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ppou_pkg::*;

    cfg_t     cfg;
    pix_in_t  in_pix_reg;
    logic     in_valid_reg;
    pix_out_t alu_res;
    pix_out_t out_pix_reg;
    logic     out_valid_reg;
    logic     out_adv;
    logic     in_adv;

    ppou_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ppou_alu u_alu (
        .cfg (cfg),
        .pix (in_pix_reg),
        .res (alu_res)
    );

    assign out_adv  = !out_valid_reg || m_tready;
    assign in_adv   = !in_valid_reg || out_adv;
    assign s_tready = in_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_adv)
                in_valid_reg <= s_tvalid;
            if (out_adv)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && s_tvalid)
            in_pix_reg <= pix_in_t'(s_tdata);
        if (out_adv && in_valid_reg)
            out_pix_reg <= alu_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;

    // a full pipe facing a stalled sink must refuse input
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while pipeline is blocked");

    // an accepted pixel lands in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted pixel lost from input stage");

    // an occupied input stage moves on whenever the result register frees up
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && (!out_valid_reg || m_tready)) |=> out_valid_reg)
        else $error("pixel lost between stages");

    // binarize gives only the two extreme levels
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && cfg.operation == OP_BINARIZE) |->
            (m_tdata[CHAN_W-1:0] == '0 || m_tdata[CHAN_W-1:0] == CHAN_MAX))
        else $error("binarize result not 0 or 255");

    // pixel-pair modes force opaque alpha
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (cfg.operation == OP_ADD_PIXELS || cfg.operation == OP_SUB_PIXELS))
            |-> (m_tdata[OUT_DATA_W-1 -: CHAN_W] == CHAN_MAX))
        else $error("pixel-pair alpha not 255");

endmodule
`default_nettype wire

### bench/tb.sv
// Testbench for the pixel point operation unit: directed table, random phases, scoreboard.
`timescale 1ns / 100ps
module tb;
    import ppou_pkg::*;

    // codes outside the package enum: spare operations pass pixel A, spare register index
    localparam logic [OP_W-1:0]  OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0]  OP_SPARE_B = 3'd7;
    localparam logic [IDX_W-1:0] REG_SPARE  = 2'd3;
    localparam int               PHASES     = 16;
    localparam int               PHASE_LEN  = 120;
    localparam int               HOLD_CYCLES = 300;

    typedef struct {
        logic        [OP_W-1:0]    mode;
        logic signed [CONST_W-1:0] offset;
        logic        [CHAN_W-1:0]  level;
        bit                        spare_poke;
        pix_in_t                   px;
        bit                        known;
        pix_out_t                  want;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // local copy of the block's registers
    logic        [OP_W-1:0]    cfg_mode = OP_ADD_CONST;
    logic signed [CONST_W-1:0] cfg_offset = '0;
    logic        [CHAN_W-1:0]  cfg_level = THRESHOLD_RESET;

    pix_out_t  offer_want = '0;
    pix_out_t  pending_px[$];
    dir_row_t  dir_rows[$];
    int        errors = 0;
    bit        steady = 1'b0;
    bit        hold_req = 1'b0;

    pixel_point_operation_unit_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [CHAN_W-1:0] sat_chan(input int v);
        if (v < 0)
            return '0;
        if (v > 255)
            return CHAN_MAX;
        return v[CHAN_W-1:0];
    endfunction

    function automatic pix_out_t point_op_of(input pix_in_t p);
        pix_out_t o;
        int k;
        int y;
        k = int'(cfg_offset);
        o = '0;
        case (cfg_mode)
            OP_ADD_CONST:
            begin
                o.out_red   = sat_chan(int'(p.a_red) + k);
                o.out_green = sat_chan(int'(p.a_green) + k);
                o.out_blue  = sat_chan(int'(p.a_blue) + k);
                o.out_alpha = p.a_alpha;
            end
            OP_SUB_CONST:
            begin
                o.out_red   = sat_chan(int'(p.a_red) - k);
                o.out_green = sat_chan(int'(p.a_green) - k);
                o.out_blue  = sat_chan(int'(p.a_blue) - k);
                o.out_alpha = p.a_alpha;
            end
            OP_ADD_PIXELS:
            begin
                o.out_red   = sat_chan(int'(p.a_red) + int'(p.b_red));
                o.out_green = sat_chan(int'(p.a_green) + int'(p.b_green));
                o.out_blue  = sat_chan(int'(p.a_blue) + int'(p.b_blue));
                o.out_alpha = CHAN_MAX;
            end
            OP_SUB_PIXELS:
            begin
                o.out_red   = sat_chan(int'(p.a_red) - int'(p.b_red));
                o.out_green = sat_chan(int'(p.a_green) - int'(p.b_green));
                o.out_blue  = sat_chan(int'(p.a_blue) - int'(p.b_blue));
                o.out_alpha = CHAN_MAX;
            end
            OP_GRAY, OP_BINARIZE:
            begin
                y = (int'(LUMA_WR) * int'(p.a_red) + int'(LUMA_WG) * int'(p.a_green)
                     + int'(LUMA_WB) * int'(p.a_blue)) >>> 16;
                if (cfg_mode == OP_BINARIZE)
                    y = (y >= int'(cfg_level)) ? 255 : 0;
                o.out_red   = y[CHAN_W-1:0];
                o.out_green = p.a_green;
                o.out_blue  = p.a_blue;
                o.out_alpha = p.a_alpha;
            end
            default:
            begin
                o.out_red   = p.a_red;
                o.out_green = p.a_green;
                o.out_blue  = p.a_blue;
                o.out_alpha = p.a_alpha;
            end
        endcase
        return o;
    endfunction

    function automatic pix_in_t mk_px(input logic [7:0] ar, ag, ab, aa, br, bg, bb);
        pix_in_t p;
        p.a_red = ar;
        p.a_green = ag;
        p.a_blue = ab;
        p.a_alpha = aa;
        p.b_red = br;
        p.b_green = bg;
        p.b_blue = bb;
        return p;
    endfunction

    function automatic pix_out_t mk_out(input logic [7:0] r, g, b, a);
        pix_out_t o;
        o.out_red = r;
        o.out_green = g;
        o.out_blue = b;
        o.out_alpha = a;
        return o;
    endfunction

    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'($urandom_range(255, 250));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic pix_in_t rand_pixel();
        pix_in_t p;
        logic [CHAN_W-1:0] v;
        p = mk_px(rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                  rand_chan(), rand_chan(), rand_chan());
        // neutral gray lands its luma right around the threshold
        if ($urandom_range(99) < 15)
        begin
            v = cfg_level + 8'($urandom_range(2));
            p.a_red = v;
            p.a_green = v;
            p.a_blue = v;
        end
        return p;
    endfunction

    task automatic add_row(input logic [OP_W-1:0] mode, input logic signed [CONST_W-1:0] offset,
                           input logic [CHAN_W-1:0] level, input bit poke, input pix_in_t px,
                           input bit known, input pix_out_t want);
        dir_row_t r;
        r.mode = mode;
        r.offset = offset;
        r.level = level;
        r.spare_poke = poke;
        r.px = px;
        r.known = known;
        r.want = want;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic send_pixel(input pix_in_t px, input pix_out_t want);
        if (!steady && $urandom_range(99) < 18)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= px;
        offer_want <= want;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_px.size() != 0)
            @(posedge clk);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_OPERATION: cfg_mode = d[OP_W-1:0];
            REG_CONSTANT:  cfg_offset = d;
            REG_THRESHOLD: cfg_level = d[CHAN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [OP_W-1:0] mode,
                              input logic signed [CONST_W-1:0] offset,
                              input logic [CHAN_W-1:0] level, input bit poke);
        // upper bits beyond each register's width are don't-care, so randomize them
        write_reg(REG_OPERATION, {6'($urandom), mode});
        write_reg(REG_CONSTANT, offset);
        write_reg(REG_THRESHOLD, {1'($urandom), level});
        if (poke)
            write_reg(REG_SPARE, 9'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic log_bad(input pix_out_t want, input pix_out_t got, input bit orphan);
        errors++;
        if (errors <= 10)
        begin
            if (orphan)
                $display("result %h arrived with nothing outstanding", got);
            else
                $display("mismatch: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                         want.out_red, want.out_green, want.out_blue, want.out_alpha,
                         got.out_red, got.out_green, got.out_blue, got.out_alpha);
        end
    endtask

    // scoreboard: queue on input transaction, check on output transaction
    always @(posedge clk)
    begin : scoreboard
        pix_out_t got;
        pix_out_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                pending_px.insert(pending_px.size(), offer_want);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (pending_px.size() == 0)
                    log_bad('0, got, 1'b1);
                else
                begin
                    want = pending_px.pop_front();
                    if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
                        got.out_blue !== want.out_blue || got.out_alpha !== want.out_alpha)
                        log_bad(want, got, 1'b0);
                end
            end
        end
    end

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            m_tready <= steady || ($urandom_range(99) >= 24);
        end
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        dir_row_t r;
        pix_in_t px;
        logic        [OP_W-1:0]    mode;
        logic signed [CONST_W-1:0] offset;
        logic        [CHAN_W-1:0]  level;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the first row matches the reset settings, so no register write precedes it
        add_row(OP_ADD_CONST, 9'h000, 8'd100, 0, mk_px(0, 128, 255, 7, 0, 0, 0),
                1, mk_out(0, 128, 255, 7));
        add_row(OP_ADD_CONST, 9'h0FF, 8'd100, 0, mk_px(1, 0, 255, 200, 9, 9, 9),
                1, mk_out(255, 255, 255, 200));
        add_row(OP_ADD_CONST, 9'h100, 8'd100, 0, mk_px(255, 254, 0, 9, 0, 0, 0),
                1, mk_out(0, 0, 0, 9));
        add_row(OP_ADD_CONST, 9'h1FF, 8'd100, 0, mk_px(0, 1, 128, 0, 0, 0, 0),
                1, mk_out(0, 0, 127, 0));
        add_row(OP_SUB_CONST, 9'h100, 8'd100, 0, mk_px(0, 5, 255, 255, 0, 0, 0),
                1, mk_out(255, 255, 255, 255));
        add_row(OP_SUB_CONST, 9'h0FF, 8'd100, 0, mk_px(255, 254, 0, 77, 0, 0, 0),
                1, mk_out(0, 0, 0, 77));
        add_row(OP_SUB_CONST, 9'd37, 8'd100, 0, mk_px(100, 30, 250, 1, 3, 4, 5), 0, '0);
        add_row(OP_ADD_PIXELS, 9'd37, 8'd100, 0, mk_px(255, 0, 128, 3, 255, 0, 127),
                1, mk_out(255, 0, 255, 255));
        add_row(OP_ADD_PIXELS, 9'd37, 8'd100, 0, mk_px(0, 0, 0, 0, 0, 0, 0),
                1, mk_out(0, 0, 0, 255));
        add_row(OP_ADD_PIXELS, 9'd37, 8'd100, 0, mk_px(200, 50, 129, 17, 55, 206, 127),
                1, mk_out(255, 255, 255, 255));
        add_row(OP_SUB_PIXELS, 9'd37, 8'd100, 0, mk_px(0, 255, 10, 128, 255, 0, 10),
                1, mk_out(0, 255, 0, 255));
        add_row(OP_SUB_PIXELS, 9'd37, 8'd100, 0, mk_px(200, 100, 50, 9, 13, 99, 51), 0, '0);
        add_row(OP_GRAY, 9'd37, 8'd100, 0, mk_px(255, 255, 255, 1, 0, 0, 0),
                1, mk_out(254, 255, 255, 1));
        add_row(OP_GRAY, 9'd37, 8'd100, 0, mk_px(0, 0, 0, 222, 255, 255, 255),
                1, mk_out(0, 0, 0, 222));
        add_row(OP_GRAY, 9'd37, 8'd100, 0, mk_px(12, 200, 33, 40, 1, 2, 3), 0, '0);
        add_row(OP_BINARIZE, 9'd37, 8'd100, 0, mk_px(255, 255, 255, 5, 0, 0, 0),
                1, mk_out(255, 255, 255, 5));
        add_row(OP_BINARIZE, 9'd37, 8'd0, 0, mk_px(0, 0, 0, 6, 0, 0, 0),
                1, mk_out(255, 0, 0, 6));
        add_row(OP_BINARIZE, 9'd37, 8'd255, 0, mk_px(255, 255, 255, 0, 0, 0, 0),
                1, mk_out(0, 255, 255, 0));
        // luma of gray 100 sits one below 100: threshold equal and one above
        add_row(OP_BINARIZE, 9'd37, 8'd99, 0, mk_px(100, 100, 100, 8, 0, 0, 0), 0, '0);
        add_row(OP_BINARIZE, 9'd37, 8'd100, 0, mk_px(100, 100, 100, 8, 0, 0, 0), 0, '0);
        add_row(OP_SPARE_A, 9'd37, 8'd100, 0, mk_px(1, 2, 3, 4, 9, 9, 9),
                1, mk_out(1, 2, 3, 4));
        add_row(OP_SPARE_B, 9'd37, 8'd100, 0, mk_px(255, 0, 255, 0, 7, 7, 7),
                1, mk_out(255, 0, 255, 0));
        // write to the unused register index must leave the settings alone
        add_row(OP_ADD_CONST, 9'd10, 8'd100, 1, mk_px(250, 0, 100, 3, 0, 0, 0),
                1, mk_out(255, 10, 110, 3));

        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            if (r.mode != cfg_mode || r.offset != cfg_offset || r.level != cfg_level ||
                r.spare_poke)
            begin
                drain();
                set_config(r.mode, r.offset, r.level, r.spare_poke);
            end
            send_pixel(r.px, r.known ? r.want : point_op_of(r.px));
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            mode = (ph < 12) ? OP_W'(ph % 6) : OP_W'($urandom_range(7));
            case ($urandom_range(3))
                0: offset = 9'h100;
                1: offset = 9'h0FF;
                default: offset = 9'($urandom);
            endcase
            case ($urandom_range(3))
                0: level = 8'd0;
                1: level = 8'd255;
                default: level = 8'($urandom);
            endcase
            drain();
            set_config(mode, offset, level, $urandom_range(3) == 0);
            steady = (ph == 5) || (ph == 9);
            // long receiver hold-off while the sender keeps offering
            if (ph == 9)
                hold_req = 1'b1;
            repeat (PHASE_LEN)
            begin
                px = rand_pixel();
                send_pixel(px, point_op_of(px));
            end
        end

        steady = 1'b0;
        drain();
        repeat (8) @(posedge clk);
        if (errors == 0 && pending_px.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
